// ===== hdl/ctcu_pkg.sv =====
`timescale 1ns / 1ps
// ctcu_pkg: shared types and constants of the causal timestamp clock unit
// no dependencies

package ctcu_pkg;

  localparam int MAX_PROCS_DEF = 16;

  localparam int REQ_W   = 2;
  localparam int PHYS_W  = 56;
  localparam int LAM_W   = 32;
  localparam int HCNT_W  = 16;
  localparam int IDX_W   = 4;
  localparam int CNT_W   = 5;
  localparam int CFG_IW  = 2;
  localparam int CFG_DW  = 5;

  localparam logic [REQ_W-1:0] REQ_LOCAL = 2'd0;
  localparam logic [REQ_W-1:0] REQ_RECV  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_MERGE = 2'd2;
  localparam logic [REQ_W-1:0] REQ_NONE  = 2'd3;

  localparam logic [CFG_IW-1:0] CFG_OWN_INDEX  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_PROC_COUNT = 2'd1;

  localparam logic [CNT_W-1:0] PROC_COUNT_RST = 5'd2;
  localparam logic [CNT_W-1:0] PROC_COUNT_MIN = 5'd2;

  typedef enum logic [1:0] {
    ALU_MAX   = 2'd0,
    ALU_INC16 = 2'd1,
    ALU_INC32 = 2'd2
  } alu_op_t;

  typedef struct packed {
    alu_op_t           op;
    logic [PHYS_W-1:0] a;
    logic [PHYS_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [PHYS_W-1:0] res;
    logic              eq;
  } alu_rsp_t;

endpackage

// ===== hdl/causal_timestamp_clock_unit_core.sv =====
`timescale 1ns / 1ps
// causal_timestamp_clock_unit_core: lamport, vector and hybrid logical clock unit
// depends on ctcu_pkg, ctcu_alu, ctcu_ram

// One word at a time: a local/send or receive event updates the lamport counter,
// hybrid clock and own vector component (skipped when own_index is out of range),
// then reads and emits the vector components one by one, waiting while out_stall
// holds; a merge word reads and writes one component, and an out-of-range merge
// or an unused request type goes straight back to idle. The single shared
// max/increment unit stepped by the sequencer and the one read port of the vector
// clock ram set the pace. in_stall is high until the word is done; the last result
// may still wait in the output register while the next word is taken.

module causal_timestamp_clock_unit_core #(
  parameter int MAX_PROCS = ctcu_pkg::MAX_PROCS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          cfg_we,
  input  logic [ctcu_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [ctcu_pkg::CFG_DW-1:0]   cfg_wdata,

  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ctcu_pkg::REQ_W-1:0]    in_req_type,
  input  logic [ctcu_pkg::PHYS_W-1:0]   in_phys_time,
  input  logic [ctcu_pkg::LAM_W-1:0]    in_msg_lamport,
  input  logic [ctcu_pkg::PHYS_W-1:0]   in_msg_phys_part,
  input  logic [ctcu_pkg::HCNT_W-1:0]   in_msg_counter,
  input  logic [ctcu_pkg::IDX_W-1:0]    in_comp_index,
  input  logic [ctcu_pkg::LAM_W-1:0]    in_comp_value,

  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ctcu_pkg::LAM_W-1:0]    out_lamport_stamp,
  output logic [ctcu_pkg::PHYS_W-1:0]   out_hlc_phys_part,
  output logic [ctcu_pkg::HCNT_W-1:0]   out_hlc_counter,
  output logic [ctcu_pkg::IDX_W-1:0]    out_vec_index,
  output logic [ctcu_pkg::LAM_W-1:0]    out_vec_value,
  output logic                          out_last
);

  localparam int AW       = $clog2(MAX_PROCS);
  localparam int EMIT_CAP = (MAX_PROCS < 16) ? MAX_PROCS : 16;

  typedef enum logic [14:0] {
    ST_IDLE     = 15'b000000000000001,
    ST_LAM_MAX  = 15'b000000000000010,
    ST_LAM_INC  = 15'b000000000000100,
    ST_PH_MAX1  = 15'b000000000001000,
    ST_PH_MAX2  = 15'b000000000010000,
    ST_EQ_OLD   = 15'b000000000100000,
    ST_EQ_ML    = 15'b000000001000000,
    ST_CNT_BASE = 15'b000000010000000,
    ST_CNT_INC  = 15'b000000100000000,
    ST_VEC_RD   = 15'b000001000000000,
    ST_VEC_WR   = 15'b000010000000000,
    ST_EMIT_RD  = 15'b000100000000000,
    ST_EMIT_LD  = 15'b001000000000000,
    ST_MRG_RD   = 15'b010000000000000,
    ST_MRG_WR   = 15'b100000000000000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [ctcu_pkg::IDX_W-1:0]    own_idx_r, own_idx_nxt;
  logic [ctcu_pkg::CNT_W-1:0]    proc_cnt_r, proc_cnt_nxt;
  logic [ctcu_pkg::LAM_W-1:0]    lam_r, lam_nxt;
  logic [ctcu_pkg::PHYS_W-1:0]   phys_r, phys_nxt;
  logic [ctcu_pkg::HCNT_W-1:0]   hcnt_r, hcnt_nxt;
  logic [ctcu_pkg::PHYS_W-1:0]   tmp_r, tmp_nxt;
  logic                          eq_old_r, eq_old_nxt;
  logic                          eq_ml_r, eq_ml_nxt;
  logic [ctcu_pkg::IDX_W-1:0]    k_r, k_nxt;
  logic [MAX_PROCS-1:0]          vld_r, vld_nxt;
  logic [AW-1:0]                 rd_addr_r, rd_addr_nxt;
  logic                          out_valid_r, out_valid_nxt;

  // latched request word
  logic                          rx_r;
  logic [ctcu_pkg::PHYS_W-1:0]   pt_r;
  logic [ctcu_pkg::LAM_W-1:0]    mlam_r;
  logic [ctcu_pkg::PHYS_W-1:0]   ml_r;
  logic [ctcu_pkg::HCNT_W-1:0]   mc_r;
  logic [ctcu_pkg::IDX_W-1:0]    ci_r;
  logic [ctcu_pkg::LAM_W-1:0]    cv_r;

  logic [ctcu_pkg::LAM_W-1:0]    out_lam_r;
  logic [ctcu_pkg::PHYS_W-1:0]   out_phys_r;
  logic [ctcu_pkg::HCNT_W-1:0]   out_hcnt_r;
  logic [ctcu_pkg::IDX_W-1:0]    out_idx_r;
  logic [ctcu_pkg::LAM_W-1:0]    out_val_r;
  logic                          out_last_r;

  ctcu_pkg::alu_req_t            alu_req;
  ctcu_pkg::alu_rsp_t            alu_rsp;

  logic                          ram_we;
  logic                          ram_re;
  logic [AW-1:0]                 ram_raddr;
  logic [ctcu_pkg::LAM_W-1:0]    ram_rdata;
  logic [ctcu_pkg::LAM_W-1:0]    rd_val;

  logic                          in_accept;
  logic                          merge_ok;
  logic                          own_ok;
  logic [ctcu_pkg::CNT_W-1:0]    cnt_eff;
  logic                          emit_last;
  logic                          out_load;

  ctcu_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  ctcu_ram #(
    .WIDTH (ctcu_pkg::LAM_W),
    .DEPTH (MAX_PROCS)
  ) u_vec_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (rd_addr_r),
    .wdata (alu_rsp.res[ctcu_pkg::LAM_W-1:0]),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign merge_ok  = ({28'd0, in_comp_index} < 32'(MAX_PROCS));
  assign own_ok    = ({28'd0, own_idx_r} < 32'(MAX_PROCS));
  assign rd_val    = vld_r[rd_addr_r] ? ram_rdata : '0;

  always_comb begin
    if (proc_cnt_r < ctcu_pkg::PROC_COUNT_MIN) begin
      cnt_eff = ctcu_pkg::PROC_COUNT_MIN;
    end else if (proc_cnt_r > ctcu_pkg::CNT_W'(EMIT_CAP)) begin
      cnt_eff = ctcu_pkg::CNT_W'(EMIT_CAP);
    end else begin
      cnt_eff = proc_cnt_r;
    end
  end

  assign emit_last = ({1'b0, k_r} == (cnt_eff - 5'd1));
  assign out_load  = (state_r == ST_EMIT_LD) && (!out_valid_r || !out_stall);

  // config writes
  always_comb begin
    own_idx_nxt  = own_idx_r;
    proc_cnt_nxt = proc_cnt_r;
    if (cfg_we) begin
      case (cfg_index)
        ctcu_pkg::CFG_OWN_INDEX:  own_idx_nxt  = cfg_wdata[ctcu_pkg::IDX_W-1:0];
        ctcu_pkg::CFG_PROC_COUNT: proc_cnt_nxt = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    lam_nxt     = lam_r;
    phys_nxt    = phys_r;
    hcnt_nxt    = hcnt_r;
    tmp_nxt     = tmp_r;
    eq_old_nxt  = eq_old_r;
    eq_ml_nxt   = eq_ml_r;
    k_nxt       = k_r;
    vld_nxt     = vld_r;
    alu_req.op  = ctcu_pkg::ALU_MAX;
    alu_req.a   = '0;
    alu_req.b   = '0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = rd_addr_r;

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          k_nxt = '0;
          case (in_req_type)
            ctcu_pkg::REQ_MERGE: state_nxt = merge_ok ? ST_MRG_RD : ST_IDLE;
            ctcu_pkg::REQ_NONE:  state_nxt = ST_IDLE;
            default:             state_nxt = ST_LAM_MAX;
          endcase
        end
      end
      ST_LAM_MAX: begin
        alu_req.a = {24'd0, lam_r};
        alu_req.b = rx_r ? {24'd0, mlam_r} : '0;
        tmp_nxt   = alu_rsp.res;
        state_nxt = ST_LAM_INC;
      end
      ST_LAM_INC: begin
        alu_req.op = ctcu_pkg::ALU_INC32;
        alu_req.a  = tmp_r;
        lam_nxt    = alu_rsp.res[ctcu_pkg::LAM_W-1:0];
        state_nxt  = ST_PH_MAX1;
      end
      ST_PH_MAX1: begin
        alu_req.a = phys_r;
        alu_req.b = rx_r ? ml_r : '0;
        tmp_nxt   = alu_rsp.res;
        state_nxt = ST_PH_MAX2;
      end
      ST_PH_MAX2: begin
        alu_req.a = tmp_r;
        alu_req.b = pt_r;
        tmp_nxt   = alu_rsp.res;
        state_nxt = ST_EQ_OLD;
      end
      ST_EQ_OLD: begin
        alu_req.a  = tmp_r;
        alu_req.b  = phys_r;
        eq_old_nxt = alu_rsp.eq;
        state_nxt  = ST_EQ_ML;
      end
      ST_EQ_ML: begin
        alu_req.a = tmp_r;
        alu_req.b = ml_r;
        eq_ml_nxt = alu_rsp.eq && rx_r;
        phys_nxt  = tmp_r;
        state_nxt = ST_CNT_BASE;
      end
      ST_CNT_BASE: begin
        alu_req.a = eq_old_r ? {40'd0, hcnt_r} : '0;
        alu_req.b = eq_ml_r ? {40'd0, mc_r} : '0;
        tmp_nxt   = alu_rsp.res;
        state_nxt = ST_CNT_INC;
      end
      ST_CNT_INC: begin
        alu_req.op = ctcu_pkg::ALU_INC16;
        alu_req.a  = tmp_r;
        hcnt_nxt   = (eq_old_r || eq_ml_r) ? alu_rsp.res[ctcu_pkg::HCNT_W-1:0] : '0;
        state_nxt  = ST_VEC_RD;
      end
      ST_VEC_RD: begin
        if (own_ok) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(own_idx_r);
          state_nxt = ST_VEC_WR;
        end else begin
          state_nxt = ST_EMIT_RD;
        end
      end
      ST_VEC_WR: begin
        alu_req.op         = ctcu_pkg::ALU_INC32;
        alu_req.a          = {24'd0, rd_val};
        ram_we             = 1'b1;
        vld_nxt[rd_addr_r] = 1'b1;
        state_nxt          = ST_EMIT_RD;
      end
      ST_EMIT_RD: begin
        ram_re    = 1'b1;
        ram_raddr = AW'(k_r);
        state_nxt = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        if (out_load) begin
          k_nxt     = k_r + 4'd1;
          state_nxt = emit_last ? ST_IDLE : ST_EMIT_RD;
        end
      end
      ST_MRG_RD: begin
        ram_re    = 1'b1;
        ram_raddr = AW'(ci_r);
        state_nxt = ST_MRG_WR;
      end
      ST_MRG_WR: begin
        alu_req.a          = {24'd0, rd_val};
        alu_req.b          = {24'd0, cv_r};
        ram_we             = 1'b1;
        vld_nxt[rd_addr_r] = 1'b1;
        state_nxt          = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign rd_addr_nxt   = ram_re ? ram_raddr : rd_addr_r;
  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      own_idx_r   <= '0;
      proc_cnt_r  <= ctcu_pkg::PROC_COUNT_RST;
      lam_r       <= '0;
      phys_r      <= '0;
      hcnt_r      <= '0;
      eq_old_r    <= 1'b0;
      eq_ml_r     <= 1'b0;
      k_r         <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      own_idx_r   <= own_idx_nxt;
      proc_cnt_r  <= proc_cnt_nxt;
      lam_r       <= lam_nxt;
      phys_r      <= phys_nxt;
      hcnt_r      <= hcnt_nxt;
      eq_old_r    <= eq_old_nxt;
      eq_ml_r     <= eq_ml_nxt;
      k_r         <= k_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    tmp_r     <= tmp_nxt;
    rd_addr_r <= rd_addr_nxt;
    if (in_accept) begin
      rx_r   <= (in_req_type == ctcu_pkg::REQ_RECV);
      pt_r   <= in_phys_time;
      mlam_r <= in_msg_lamport;
      ml_r   <= in_msg_phys_part;
      mc_r   <= in_msg_counter;
      ci_r   <= in_comp_index;
      cv_r   <= in_comp_value;
    end
    if (out_load) begin
      out_lam_r  <= lam_r;
      out_phys_r <= phys_r;
      out_hcnt_r <= hcnt_r;
      out_idx_r  <= k_r;
      out_val_r  <= rd_val;
      out_last_r <= emit_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_lamport_stamp = out_lam_r;
  assign out_hlc_phys_part = out_phys_r;
  assign out_hlc_counter   = out_hcnt_r;
  assign out_vec_index     = out_idx_r;
  assign out_vec_value     = out_val_r;
  assign out_last          = out_last_r;

  a_lam_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> lam_r >= $past(lam_r))
    else $error("lamport counter went backward");

  a_phys_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> phys_r >= $past(phys_r))
    else $error("hybrid physical part went backward");

  a_last_ends_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_last_r == (state_r == ST_IDLE))
    else $error("last flag out of step with end of emission");

endmodule

// ===== hdl/ctcu_ram.sv =====
`timescale 1ns / 1ps
// ctcu_ram: generic single write port ram with registered read
// no dependencies

module ctcu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/ctcu_alu.sv =====
`timescale 1ns / 1ps
// ctcu_alu: shared max / saturating increment unit with equality flag
// depends on ctcu_pkg

module ctcu_alu (
  input  ctcu_pkg::alu_req_t req,
  output ctcu_pkg::alu_rsp_t rsp
);

  always_comb begin
    rsp.eq  = (req.a == req.b);
    rsp.res = req.a;
    case (req.op)
      ctcu_pkg::ALU_MAX: begin
        rsp.res = (req.a >= req.b) ? req.a : req.b;
      end
      ctcu_pkg::ALU_INC16: begin
        rsp.res = (req.a[15:0] == 16'hFFFF) ? {40'd0, req.a[15:0]}
                                            : {40'd0, req.a[15:0] + 16'd1};
      end
      ctcu_pkg::ALU_INC32: begin
        rsp.res = (req.a[31:0] == 32'hFFFF_FFFF) ? {24'd0, req.a[31:0]}
                                                 : {24'd0, req.a[31:0] + 32'd1};
      end
      default: begin
        rsp.res = req.a;
      end
    endcase
  end

endmodule

// ===== dv/causal_timestamp_clock_unit_core_tb.sv =====
`timescale 1ns / 1ps
// causal_timestamp_clock_unit_core_tb: self-checking bench for the causal timestamp unit
// predicts lamport, vector and hybrid clock stamps word by word and checks every output word
// depends on ctcu_pkg and causal_timestamp_clock_unit_core

module causal_timestamp_clock_unit_core_tb;
  import ctcu_pkg::*;

  localparam int EMIT_CAP = (MAX_PROCS_DEF < 16) ? MAX_PROCS_DEF : 16;
  localparam int SETTLE_CYCLES = 64;
  localparam int QUIET_LIMIT = 2000;
  localparam logic [CFG_IW-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IW-1:0] CFG_SPARE_HI = 2'd3;
  localparam logic [PHYS_W-1:0] PHYS_MAX = {PHYS_W{1'b1}};
  localparam logic [LAM_W-1:0] LAM_MAX = {LAM_W{1'b1}};

  typedef struct packed {
    logic [REQ_W-1:0]  kind;
    logic [PHYS_W-1:0] phys;
    logic [LAM_W-1:0]  msg_lam;
    logic [PHYS_W-1:0] msg_phys;
    logic [HCNT_W-1:0] msg_cnt;
    logic [IDX_W-1:0]  comp_idx;
    logic [LAM_W-1:0]  comp_val;
  } clock_req_t;

  typedef struct packed {
    logic [LAM_W-1:0]  lamport;
    logic [PHYS_W-1:0] phys;
    logic [HCNT_W-1:0] cnt;
    logic [IDX_W-1:0]  idx;
    logic [LAM_W-1:0]  val;
    logic              last;
  } stamp_word_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CFG_IW-1:0]   cfg_index = '0;
  logic [CFG_DW-1:0]   cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [REQ_W-1:0]    in_req_type = '0;
  logic [PHYS_W-1:0]   in_phys_time = '0;
  logic [LAM_W-1:0]    in_msg_lamport = '0;
  logic [PHYS_W-1:0]   in_msg_phys_part = '0;
  logic [HCNT_W-1:0]   in_msg_counter = '0;
  logic [IDX_W-1:0]    in_comp_index = '0;
  logic [LAM_W-1:0]    in_comp_value = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [LAM_W-1:0]    out_lamport_stamp;
  logic [PHYS_W-1:0]   out_hlc_phys_part;
  logic [HCNT_W-1:0]   out_hlc_counter;
  logic [IDX_W-1:0]    out_vec_index;
  logic [LAM_W-1:0]    out_vec_value;
  logic                out_last;

  causal_timestamp_clock_unit_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_phys_time      (in_phys_time),
    .in_msg_lamport    (in_msg_lamport),
    .in_msg_phys_part  (in_msg_phys_part),
    .in_msg_counter    (in_msg_counter),
    .in_comp_index     (in_comp_index),
    .in_comp_value     (in_comp_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_lamport_stamp (out_lamport_stamp),
    .out_hlc_phys_part (out_hlc_phys_part),
    .out_hlc_counter   (out_hlc_counter),
    .out_vec_index     (out_vec_index),
    .out_vec_value     (out_vec_value),
    .out_last          (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted clock state and register copies
  logic [IDX_W-1:0]  own_sel = '0;
  logic [CNT_W-1:0]  comp_total = PROC_COUNT_RST;
  logic [LAM_W-1:0]  lam_now = '0;
  logic [LAM_W-1:0]  vclk [MAX_PROCS_DEF];
  logic [PHYS_W-1:0] hlc_l = '0;
  logic [HCNT_W-1:0] hlc_c = '0;

  clock_req_t  pending_q [$];
  stamp_word_t stamp_q [$];
  clock_req_t  drv_item;
  int fail_count = 0;
  int quiet_cycles = 0;
  int tx_gap = 0;
  int rx_hold = 0;
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;

  // stimulus shaping state
  logic [PHYS_W-1:0] wall_us = 56'd10_000;
  logic [LAM_W-1:0]  lam_guess = '0;

  initial begin
    for (int i = 0; i < MAX_PROCS_DEF; i++) vclk[i] = '0;
  end

  function automatic logic [LAM_W-1:0] sat32(input logic [LAM_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic [HCNT_W-1:0] sat16(input logic [HCNT_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic [PHYS_W-1:0] max56(input logic [PHYS_W-1:0] a,
                                              input logic [PHYS_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic [PHYS_W-1:0] rand56();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[PHYS_W-1:0];
  endfunction

  task automatic note_fail(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("error: %s", msg);
  endtask

  // apply one accepted word to the clocks and queue the stamp words it causes
  task automatic advance_clocks(input clock_req_t e);
    logic [PHYS_W-1:0] prev;
    stamp_word_t w;
    int n;
    prev = hlc_l;
    case (e.kind)
      REQ_MERGE: begin
        if (e.comp_idx < MAX_PROCS_DEF && e.comp_val > vclk[e.comp_idx])
          vclk[e.comp_idx] = e.comp_val;
      end
      REQ_LOCAL: begin
        lam_now = sat32(lam_now);
        if (own_sel < MAX_PROCS_DEF) vclk[own_sel] = sat32(vclk[own_sel]);
        hlc_l = max56(prev, e.phys);
        hlc_c = (hlc_l == prev) ? sat16(hlc_c) : '0;
      end
      REQ_RECV: begin
        lam_now = sat32((e.msg_lam > lam_now) ? e.msg_lam : lam_now);
        hlc_l = max56(max56(prev, e.msg_phys), e.phys);
        if (hlc_l == prev && hlc_l == e.msg_phys)
          hlc_c = sat16((e.msg_cnt > hlc_c) ? e.msg_cnt : hlc_c);
        else if (hlc_l == prev)
          hlc_c = sat16(hlc_c);
        else if (hlc_l == e.msg_phys)
          hlc_c = sat16(e.msg_cnt);
        else
          hlc_c = '0;
        if (own_sel < MAX_PROCS_DEF) vclk[own_sel] = sat32(vclk[own_sel]);
      end
      default: ;
    endcase
    if (e.kind == REQ_LOCAL || e.kind == REQ_RECV) begin
      n = (comp_total < PROC_COUNT_MIN) ? PROC_COUNT_MIN :
          (comp_total > EMIT_CAP) ? EMIT_CAP : comp_total;
      for (int k = 0; k < n; k++) begin
        w.lamport = lam_now;
        w.phys = hlc_l;
        w.cnt = hlc_c;
        w.idx = k[IDX_W-1:0];
        w.val = vclk[k];
        w.last = (k == n - 1);
        stamp_q.push_back(w);
      end
    end
  endtask

  task automatic queue_item(input logic [REQ_W-1:0] kind, input logic [PHYS_W-1:0] pt,
                            input logic [LAM_W-1:0] mlam, input logic [PHYS_W-1:0] ml,
                            input logic [HCNT_W-1:0] mc, input logic [IDX_W-1:0] ci,
                            input logic [LAM_W-1:0] cv);
    clock_req_t e;
    e = '{kind, pt, mlam, ml, mc, ci, cv};
    pending_q.push_back(e);
  endtask

  // mostly well-ordered traffic around a slowly moving wall clock, plus some noise
  task automatic queue_traffic(input int n);
    clock_req_t e;
    int pick;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      wall_us = wall_us + $urandom_range(0, 2);
      e.kind = REQ_RECV;
      e.phys = wall_us;
      e.msg_lam = (lam_guess > 4) ? lam_guess - 4 + $urandom_range(0, 8)
                                  : $urandom_range(0, 8);
      e.msg_phys = wall_us - 3 + $urandom_range(0, 6);
      e.msg_cnt = $urandom_range(0, 12);
      e.comp_idx = $urandom_range(0, 15);
      e.comp_val = $urandom_range(0, lam_guess + 4);
      if (pick < 35) begin
        e.kind = REQ_LOCAL;
        e.msg_lam = $urandom();
        e.msg_phys = rand56();
        e.msg_cnt = $urandom_range(0, 16'hFFFF);
      end else if (pick < 85 && pick >= 65) begin
        e.kind = REQ_MERGE;
        e.phys = rand56();
        e.msg_phys = rand56();
        e.msg_lam = $urandom();
      end else if (pick < 90 && pick >= 85) begin
        e.kind = REQ_NONE;
        e.phys = rand56();
        e.msg_phys = rand56();
        e.msg_lam = $urandom();
        e.comp_val = $urandom();
      end else if (pick < 95 && pick >= 90) begin
        e.kind = REQ_MERGE;
        e.comp_val = $urandom();
      end else if (pick >= 95) begin
        // skewed clocks and out-of-order messages
        e.kind = ($urandom_range(0, 1) != 0) ? REQ_RECV : REQ_LOCAL;
        e.phys = wall_us - $urandom_range(0, 1000);
        e.msg_phys = ($urandom_range(0, 1) != 0) ? wall_us + $urandom_range(0, 100000)
                                                 : wall_us - $urandom_range(0, 5000);
        e.msg_lam = $urandom();
        e.msg_cnt = $urandom_range(0, 16'hFFFF);
        if (e.kind == REQ_RECV && e.msg_phys > wall_us) wall_us = e.msg_phys;
      end
      if (e.kind == REQ_RECV && e.msg_lam > lam_guess)
        lam_guess = e.msg_lam + 1;
      else if (e.kind == REQ_LOCAL || e.kind == REQ_RECV)
        lam_guess = lam_guess + 1;
      pending_q.push_back(e);
    end
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_OWN_INDEX:  own_sel = data[IDX_W-1:0];
      CFG_PROC_COUNT: comp_total = data;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [CFG_DW-1:0] own_data,
                           input logic [CFG_DW-1:0] cnt_data, input bit spare);
    write_reg(CFG_OWN_INDEX, own_data);
    write_reg(CFG_PROC_COUNT, cnt_data);
    if (spare) begin
      write_reg(CFG_SPARE_LO, 5'd9);
      write_reg(CFG_SPARE_HI, 5'd31);
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    @(negedge clk);
    while (pending_q.size() != 0 || in_valid || stamp_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        advance_clocks(drv_item);
        tx_gap = tx_burst ? 0 : $urandom_range(0, 15);
      end
      if (!in_valid || !in_stall) begin
        if (tx_gap != 0) begin
          tx_gap = tx_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_q.size() != 0) begin
          drv_item = pending_q.pop_front();
          if ($urandom_range(0, 15) == 0) tx_burst = !tx_burst;
          in_valid <= 1'b1;
          in_req_type <= drv_item.kind;
          in_phys_time <= drv_item.phys;
          in_msg_lamport <= drv_item.msg_lam;
          in_msg_phys_part <= drv_item.msg_phys;
          in_msg_counter <= drv_item.msg_cnt;
          in_comp_index <= drv_item.comp_idx;
          in_comp_value <= drv_item.comp_val;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and output stall
  always @(posedge clk) begin
    stamp_word_t got;
    stamp_word_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {out_lamport_stamp, out_hlc_phys_part, out_hlc_counter,
               out_vec_index, out_vec_value, out_last};
        if (stamp_q.size() == 0) begin
          note_fail($sformatf("unexpected stamp word lam %0h phys %0h cnt %0h idx %0d val %0h last %0b",
                              got.lamport, got.phys, got.cnt, got.idx, got.val, got.last));
        end else begin
          want = stamp_q.pop_front();
          if (got !== want)
            note_fail($sformatf({"stamp word mismatch: expected lam %0h phys %0h cnt %0h ",
                                 "idx %0d val %0h last %0b, got lam %0h phys %0h cnt %0h ",
                                 "idx %0d val %0h last %0b"},
                                want.lamport, want.phys, want.cnt, want.idx, want.val,
                                want.last, got.lamport, got.phys, got.cnt, got.idx,
                                got.val, got.last));
        end
        if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
        rx_hold = rx_burst ? 0 : $urandom_range(0, 15);
      end else if (rx_hold != 0) begin
        rx_hold = rx_hold - 1;
      end
      out_stall <= (rx_hold != 0);
    end
  end

  // watchdog on handshake progress
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("causal_timestamp_clock_unit_core regression: fail");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: hybrid rule branches, merges and the unused request type
    queue_item(REQ_LOCAL, 56'd0, 32'd0, 56'd0, 16'd0, 4'd0, 32'd0);
    queue_item(REQ_LOCAL, 56'd0, 32'd0, 56'd0, 16'd0, 4'd0, 32'd0);
    queue_item(REQ_LOCAL, 56'd100, 32'd0, 56'd0, 16'd0, 4'd0, 32'd0);
    queue_item(REQ_RECV, 56'd50, 32'd10, 56'd100, 16'd7, 4'd0, 32'd0);
    queue_item(REQ_RECV, 56'd0, 32'd3, 56'd100, 16'd2, 4'd0, 32'd0);
    queue_item(REQ_RECV, 56'd0, 32'd0, 56'd50, 16'd99, 4'd0, 32'd0);
    queue_item(REQ_RECV, 56'd150, 32'd40, 56'd200, 16'd40, 4'd0, 32'd0);
    queue_item(REQ_RECV, 56'd300, 32'd0, 56'd210, 16'd3, 4'd0, 32'd0);
    queue_item(REQ_RECV, 56'd400, 32'd0, 56'd0, 16'd0, 4'd0, 32'd0);
    queue_item(REQ_MERGE, 56'd0, 32'd0, 56'd0, 16'd0, 4'd1, 32'd50);
    queue_item(REQ_MERGE, 56'd0, 32'd0, 56'd0, 16'd0, 4'd1, 32'd20);
    queue_item(REQ_MERGE, 56'd0, 32'd0, 56'd0, 16'd0, 4'd15, 32'd7);
    queue_item(REQ_NONE, rand56(), $urandom(), rand56(), 16'hBEEF, 4'd9, $urandom());
    queue_item(REQ_LOCAL, 56'd400, 32'd0, 56'd0, 16'd0, 4'd0, 32'd0);
    settle();

    configure(5'd15, 5'd16, 1'b0);
    queue_traffic(32);
    settle();

    configure(5'd5, 5'd0, 1'b1);
    queue_traffic(32);
    settle();

    configure(5'h1A, 5'd17, 1'b0);
    queue_traffic(32);
    settle();

    configure(5'd0, 5'd1, 1'b0);
    queue_traffic(32);
    settle();

    // clocks near the top of their range
    configure(5'($urandom_range(0, 31)), 5'd31, 1'b0);
    wall_us = PHYS_MAX - 56'd2_000_000;
    lam_guess = 32'hFFFF_0000;
    queue_traffic(32);
    settle();

    // saturation of lamport, hybrid counter and vector components
    configure(5'd3, 5'd16, 1'b0);
    queue_item(REQ_RECV, 56'd0, LAM_MAX, PHYS_MAX, 16'hFFFE, 4'd0, 32'd0);
    queue_item(REQ_LOCAL, PHYS_MAX, 32'd0, 56'd0, 16'd0, 4'd0, 32'd0);
    queue_item(REQ_MERGE, 56'd0, 32'd0, 56'd0, 16'd0, 4'd3, LAM_MAX);
    queue_item(REQ_LOCAL, 56'd0, 32'd0, 56'd0, 16'd0, 4'd0, 32'd0);
    queue_item(REQ_RECV, PHYS_MAX, 32'd0, PHYS_MAX, 16'hFFFF, 4'd0, 32'd0);
    queue_item(REQ_MERGE, 56'd0, 32'd0, 56'd0, 16'd0, 4'd15, 32'hFFFF_FFFE);
    queue_item(REQ_LOCAL, PHYS_MAX, 32'd0, 56'd0, 16'd0, 4'd0, 32'd0);
    queue_item(REQ_NONE, PHYS_MAX, LAM_MAX, PHYS_MAX, 16'hFFFF, 4'hF, LAM_MAX);
    settle();

    if (fail_count == 0 && stamp_q.size() == 0)
      $display("causal_timestamp_clock_unit_core regression: pass");
    else
      $display("causal_timestamp_clock_unit_core regression: fail");
    $finish;
  end

endmodule
